// File: hdl/cumulative_cost_row_dp_defines.svh
// ----------------------------------------------------------------------------
// cumulative cost row dp assertion macros
// shared property forms for the block checker
// ----------------------------------------------------------------------------
`ifndef CUMULATIVE_COST_ROW_DP_DEFINES_SVH
`define CUMULATIVE_COST_ROW_DP_DEFINES_SVH

// same-cycle implication
`define CCRD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCRD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ccrd_pkg.sv
// ----------------------------------------------------------------------------
// ccrd_pkg
// types and constants of the cumulative cost row dp block
// ----------------------------------------------------------------------------
package ccrd_pkg;

    localparam int PIX_W  = 24;
    localparam int COST_W = 40;
    localparam int RW_W   = 12;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef logic signed [COST_W-1:0] cost_t;

    typedef struct packed {
        cost_t cost;
        logic  row_end;
    } result_t;

    localparam cost_t COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
    localparam cost_t COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

    // register indexes
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_CHANNEL = 2'd1;
    localparam logic [1:0] CFG_WIDTH   = 2'd2;

    // channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    // neighbor selection
    localparam logic MODE_MIN = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    localparam logic [RW_W-1:0] RW_RESET = 12'd2048;

endpackage

// File: hdl/ccrd_ram.sv
// ----------------------------------------------------------------------------
// ccrd_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ccrd_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/ccrd_out_buf.sv
// ----------------------------------------------------------------------------
// ccrd_out_buf
// two-entry output register with skid stage
// ----------------------------------------------------------------------------
module ccrd_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  ccrd_pkg::result_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output ccrd_pkg::result_t pop_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    ccrd_pkg::result_t out_data_reg;
    ccrd_pkg::result_t skid_data_reg;
    logic              push;
    logic              pop;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = out_valid_reg && pop_ready;
    assign pop_valid  = out_valid_reg;
    assign pop_data   = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_data_reg <= push_data;
            end else begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule

// File: hdl/cumulative_cost_row_dp.sv
// ----------------------------------------------------------------------------
// cumulative_cost_row_dp
// row by row cumulative cost map over an rgba pixel stream, one line store
// ----------------------------------------------------------------------------
//  channel   direction  handshake            word
//  s_        in         s_valid / s_ready    one pixel, four channels + frame_start
//  m_        out        m_valid / m_ready    cumulative cost + row_end
//  cfg_      in         cfg_valid/cfg_ready  register index + data
//
//  one pixel per cycle while s_ready is high; each result is registered in the output buffer
//  the line store gives one read and one write per cycle; the right neighbor
//  is read one pixel ahead, row start neighbors come from two column registers
//  synchronous active-low reset; line store contents are not cleared
//  s_ready drops only while both output stages hold words; cfg_ready is high
// ----------------------------------------------------------------------------
module cumulative_cost_row_dp #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [11:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [23:0]    s_red_value,
    input  logic signed [23:0]    s_green_value,
    input  logic signed [23:0]    s_blue_value,
    input  logic signed [23:0]    s_alpha_value,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [39:0]    m_cost_value,
    output logic                  m_row_end
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (IDX_W + 1 > ccrd_pkg::RW_W) ? IDX_W + 1 : ccrd_pkg::RW_W;

    logic                        mode_reg;
    logic [1:0]                  channel_reg;
    logic [ccrd_pkg::RW_W-1:0]   width_reg;

    logic [IDX_W-1:0]            col_reg, col_next;
    logic                        first_row_reg, first_row_next;
    logic                        right_ram_reg, right_ram_next;
    ccrd_pkg::cost_t             centre_reg, centre_next;
    ccrd_pkg::cost_t             right_reg, right_next;
    ccrd_pkg::cost_t             hold_reg;
    ccrd_pkg::cost_t             col0_reg;
    ccrd_pkg::cost_t             col1_reg;

    logic                        accept;
    logic [CMP_W-1:0]            width_ext;
    logic [CMP_W-1:0]            width_eff;
    logic [CMP_W-1:0]            col_plus1;
    logic [IDX_W-1:0]            col;
    logic                        last;
    logic                        first;
    ccrd_pkg::pix_t              pixel;
    ccrd_pkg::cost_t             right;
    ccrd_pkg::cost_t             ram_rdata;
    ccrd_pkg::cost_t             best_lc;
    ccrd_pkg::cost_t             best;
    logic signed [ccrd_pkg::COST_W:0] sum;
    ccrd_pkg::cost_t             cost;
    ccrd_pkg::result_t           result;
    ccrd_pkg::result_t           m_result;

    function automatic ccrd_pkg::cost_t pick(input logic mode, input ccrd_pkg::cost_t a,
                                             input ccrd_pkg::cost_t b);
        if (mode == ccrd_pkg::MODE_MAX) begin
            return (a > b) ? a : b;
        end
        return (a < b) ? a : b;
    endfunction

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= ccrd_pkg::MODE_MIN;
            channel_reg <= ccrd_pkg::CH_RED;
            width_reg   <= ccrd_pkg::RW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ccrd_pkg::CFG_MODE:    mode_reg    <= cfg_data[0];
                ccrd_pkg::CFG_CHANNEL: channel_reg <= cfg_data[1:0];
                ccrd_pkg::CFG_WIDTH:   width_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // column and row position
    assign accept    = s_valid && s_ready;
    assign width_ext = CMP_W'(width_reg);

    always_comb begin
        if (width_ext == '0) begin
            width_eff = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
    end

    assign col       = s_frame_start ? '0 : col_reg;
    assign col_plus1 = CMP_W'(col) + CMP_W'(1);
    assign last      = (col_plus1 >= width_eff);
    assign first     = s_frame_start || first_row_reg;

    always_comb begin
        case (channel_reg)
            ccrd_pkg::CH_RED:   pixel = s_red_value;
            ccrd_pkg::CH_GREEN: pixel = s_green_value;
            ccrd_pkg::CH_BLUE:  pixel = s_blue_value;
            default:            pixel = s_alpha_value;
        endcase
    end

    // neighbors below and cost
    assign right   = right_ram_reg ? ram_rdata : right_reg;
    assign best_lc = (col != '0) ? pick(mode_reg, centre_reg, hold_reg) : centre_reg;
    assign best    = last ? best_lc : pick(mode_reg, best_lc, right);
    assign sum     = (ccrd_pkg::COST_W+1)'(best) + (ccrd_pkg::COST_W+1)'(pixel);

    always_comb begin
        if (first) begin
            cost = ccrd_pkg::COST_W'(pixel);
        end else if (sum[ccrd_pkg::COST_W] != sum[ccrd_pkg::COST_W-1]) begin
            cost = sum[ccrd_pkg::COST_W] ? ccrd_pkg::COST_MIN : ccrd_pkg::COST_MAX;
        end else begin
            cost = sum[ccrd_pkg::COST_W-1:0];
        end
    end

    // state for the next pixel
    always_comb begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        right_ram_next = right_ram_reg;
        centre_next    = centre_reg;
        right_next     = right_reg;
        if (accept) begin
            if (last) begin
                col_next       = '0;
                first_row_next = 1'b0;
                right_ram_next = 1'b0;
                centre_next    = (col == IDX_W'(0)) ? cost : col0_reg;
                right_next     = (col == IDX_W'(1)) ? cost : col1_reg;
            end else begin
                col_next       = col + IDX_W'(1);
                first_row_next = first;
                right_ram_next = 1'b1;
                centre_next    = right;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            right_ram_reg <= 1'b0;
            centre_reg    <= '0;
            hold_reg      <= '0;
        end else begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
            right_ram_reg <= right_ram_next;
            centre_reg    <= centre_next;
            if (accept) begin
                hold_reg <= centre_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        right_reg <= right_next;
        if (accept && col == IDX_W'(0)) begin
            col0_reg <= cost;
        end
        if (accept && col == IDX_W'(1)) begin
            col1_reg <= cost;
        end
    end

    ccrd_ram #(
        .WIDTH (ccrd_pkg::COST_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col),
        .wdata (cost),
        .re    (accept),
        .raddr (col + IDX_W'(2)),
        .rdata (ram_rdata)
    );

    // output stage
    assign result.cost    = cost;
    assign result.row_end = last;

    ccrd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (result),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_data   (m_result)
    );

    assign m_cost_value = m_result.cost;
    assign m_row_end    = m_result.row_end;

endmodule

// File: hdl/ccrd_checker.sv
// ----------------------------------------------------------------------------
// ccrd_checker
// port-level checks of the cumulative cost row dp block
// ----------------------------------------------------------------------------
`include "cumulative_cost_row_dp_defines.svh"

module ccrd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [39:0] m_cost_value,
    input logic               m_row_end
);

    // a stalled word holds
    `CCRD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_cost_value) && $stable(m_row_end),
        "output word changed while stalled")

    // every accepted pixel yields a word
    `CCRD_ASSERT_NEXT(a_accept_out, aclk, aresetn, s_valid && s_ready, m_valid,
        "no word after accepted pixel")

    // input stalls only with a word pending
    `CCRD_ASSERT_NOW(a_stall_full, aclk, aresetn, !s_ready, m_valid,
        "input stalled with empty output")

    // input ready falls only after an output stall
    `CCRD_ASSERT_NOW(a_ready_fall, aclk, aresetn, $fell(s_ready),
        $past(m_valid && !m_ready), "ready fell without output stall")

endmodule

bind cumulative_cost_row_dp ccrd_checker u_ccrd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_cost_value  (m_cost_value),
    .m_row_end     (m_row_end)
);
